// ----- sv/dmz_pkg.sv -----
// Shared types, constants and the hash step function of the minimizer stream.
`default_nettype none

package dmz_pkg;

    // k-mer length in bases and the packed k-mer width in bits
    localparam int unsigned KMER_LEN = 19;
    localparam int unsigned KBITS    = 2 * KMER_LEN;

    // result field widths
    localparam int unsigned MIN_W  = 38;
    localparam int unsigned SLOT_W = 10;

    // the mix hash runs as a chain of seven dependent steps
    localparam int unsigned HASH_STEPS = 7;
    localparam int unsigned STEP_W     = 3;

    // complement of a 2-bit base code
    localparam logic [1:0] BASE_COMP = 2'h2;

    typedef logic [KBITS-1:0] kmer_t;

    typedef enum logic {
        CMD_KMER,
        CMD_END
    } cmd_kind_t;

    // one queued command from the front to the back
    typedef struct packed {
        cmd_kind_t kind;
        kmer_t     canon;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HASH,
        ST_WRITE,
        ST_SCAN,
        ST_CHECK
    } back_state_t;

    // one step of the integer mix hash at the k-mer width
    function automatic kmer_t mix_step(input kmer_t k, input logic [STEP_W-1:0] step);
        kmer_t r;
        begin
            case (step)
                3'd0:    r = (~k) + (k << 21);
                3'd1:    r = k ^ (k >> 24);
                3'd2:    r = k + (k << 3) + (k << 8);
                3'd3:    r = k ^ (k >> 14);
                3'd4:    r = k + (k << 2) + (k << 4);
                3'd5:    r = k ^ (k >> 28);
                3'd6:    r = k + (k << 31);
                default: r = k;
            endcase
            return r;
        end
    endfunction

endpackage

`default_nettype wire

// ----- sv/dmz_front.sv -----
// Front end: accepts bases, shifts the k-mers and queues canonical k-mers and end marks.
`default_nettype none

module dmz_front
    import dmz_pkg::*;
#(
    parameter int unsigned MAX_BASES = 512
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic [7:0] in_base,
    input  wire logic       in_end,
    input  wire logic       q_full,
    output logic            in_ready,
    output logic            q_push,
    output cmd_t            q_cmd
);

    localparam int unsigned BW = $clog2(MAX_BASES + 1);

    kmer_t         fwd_reg, fwd_next;
    kmer_t         rc_reg, rc_next;
    logic [BW-1:0] seen_reg, seen_next;
    logic [BW-1:0] seen_inc;
    logic [1:0]    code;
    logic          accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign code     = in_base[2:1];
    assign seen_inc = seen_reg + BW'(1);

    always_comb
    begin
        fwd_next    = fwd_reg;
        rc_next     = rc_reg;
        seen_next   = seen_reg;
        q_push      = 1'b0;
        q_cmd.kind  = CMD_KMER;
        q_cmd.canon = '0;
        if (accept)
        begin
            if (in_end)
            begin
                // end mark: queue it and start a fresh sequence
                q_push     = 1'b1;
                q_cmd.kind = CMD_END;
                fwd_next   = '0;
                rc_next    = '0;
                seen_next  = '0;
            end
            else if (32'(seen_reg) < MAX_BASES)
            begin
                seen_next = seen_inc;
                fwd_next  = {fwd_reg[KBITS-3:0], code};
                rc_next   = {code ^ BASE_COMP, rc_reg[KBITS-1:2]};
                if (32'(seen_inc) >= KMER_LEN)
                begin
                    q_push      = 1'b1;
                    q_cmd.canon = (fwd_next < rc_next) ? fwd_next : rc_next;
                end
            end
            // bases past the limit drop here
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg  <= '0;
            rc_reg   <= '0;
            seen_reg <= '0;
        end
        else
        begin
            fwd_reg  <= fwd_next;
            rc_reg   <= rc_next;
            seen_reg <= seen_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/dmz_fifo.sv -----
// Short command queue between the front end and the back end.
`default_nettype none

module dmz_fifo
    import dmz_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    input  wire logic pop,
    output logic      full,
    output logic      nonempty,
    output cmd_t      head
);

    localparam int unsigned DEPTH = 4;
    localparam int unsigned AW    = $clog2(DEPTH);
    localparam int unsigned CW    = $clog2(DEPTH + 1);

    cmd_t          entry_reg [DEPTH];
    logic [AW-1:0] wr_reg, wr_next;
    logic [AW-1:0] rd_reg, rd_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    assign full     = (cnt_reg == CW'(DEPTH));
    assign nonempty = (cnt_reg != '0);
    assign head     = entry_reg[rd_reg];

    always_comb
    begin
        wr_next  = push ? wr_reg + AW'(1) : wr_reg;
        rd_next  = pop ? rd_reg + AW'(1) : rd_reg;
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// ----- sv/dmz_back.sv -----
// Back end: hashes queued k-mers, keeps the hash window, finds its minimum and emits results.
`default_nettype none

module dmz_back
    import dmz_pkg::*;
#(
    parameter int unsigned WINDOW_LEN = 16
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cmd_valid,
    input  wire cmd_t               cmd,
    output logic                    cmd_pop,
    output logic                    res_valid,
    input  wire logic               res_ready,
    output logic [MIN_W-1:0]        res_min,
    output logic [SLOT_W-1:0]       res_slot,
    output logic                    res_done
);

    localparam int unsigned PW = $clog2(WINDOW_LEN);
    localparam int unsigned SW = $clog2(WINDOW_LEN + 1);

    back_state_t       state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    kmer_t             hash_reg, hash_next;
    logic [PW-1:0]     ptr_reg, ptr_next;
    logic [SW-1:0]     seen_reg, seen_next;
    logic [SW-1:0]     seen_wr;
    logic [SW-1:0]     scan_reg, scan_next;
    kmer_t             min_reg, min_next;
    kmer_t             last_reg, last_next;
    logic [SLOT_W-1:0] count_reg, count_next;
    logic              out_valid_reg, out_valid_next;
    logic [MIN_W-1:0]  out_min_reg, out_min_next;
    logic [SLOT_W-1:0] out_slot_reg, out_slot_next;
    logic              out_done_reg, out_done_next;
    logic              out_free;
    logic              mem_we;
    logic [PW-1:0]     rd_addr;
    kmer_t             rd_data_reg;
    kmer_t             window_mem [WINDOW_LEN];

    assign out_free  = !out_valid_reg || res_ready;
    assign seen_wr   = (seen_reg == SW'(WINDOW_LEN)) ? seen_reg : seen_reg + SW'(1);
    assign rd_addr   = scan_reg[PW-1:0];
    assign res_valid = out_valid_reg;
    assign res_min   = out_min_reg;
    assign res_slot  = out_slot_reg;
    assign res_done  = out_done_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid && cmd.kind == CMD_KMER)
                begin
                    state_next = ST_HASH;
                end
            end
            ST_HASH:
            begin
                if (step_reg == STEP_W'(HASH_STEPS - 1))
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                state_next = (seen_wr == SW'(WINDOW_LEN)) ? ST_SCAN : ST_IDLE;
            end
            ST_SCAN:
            begin
                if (scan_reg == SW'(WINDOW_LEN))
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (min_reg == last_reg || out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        step_next      = step_reg;
        hash_next      = hash_reg;
        ptr_next       = ptr_reg;
        seen_next      = seen_reg;
        scan_next      = scan_reg;
        min_next       = min_reg;
        last_next      = last_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !res_ready;
        out_min_next   = out_min_reg;
        out_slot_next  = out_slot_reg;
        out_done_next  = out_done_reg;
        cmd_pop        = 1'b0;
        mem_we         = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd.kind == CMD_END)
                    begin
                        if (out_free)
                        begin
                            cmd_pop        = 1'b1;
                            out_valid_next = 1'b1;
                            out_min_next   = '0;
                            out_slot_next  = count_reg;
                            out_done_next  = 1'b1;
                            ptr_next       = '0;
                            seen_next      = '0;
                            last_next      = '1;
                            count_next     = '0;
                        end
                    end
                    else
                    begin
                        cmd_pop   = 1'b1;
                        hash_next = cmd.canon;
                        step_next = '0;
                    end
                end
            end
            ST_HASH:
            begin
                hash_next = mix_step(hash_reg, step_reg);
                step_next = step_reg + STEP_W'(1);
            end
            ST_WRITE:
            begin
                mem_we    = 1'b1;
                ptr_next  = (ptr_reg == PW'(WINDOW_LEN - 1)) ? '0 : ptr_reg + PW'(1);
                seen_next = seen_wr;
                scan_next = '0;
            end
            ST_SCAN:
            begin
                // read data comes from the registered read port, in the cycle after its address
                scan_next = scan_reg + SW'(1);
                if (scan_reg != '0)
                begin
                    if (scan_reg == SW'(1) || rd_data_reg < min_reg)
                    begin
                        min_next = rd_data_reg;
                    end
                end
            end
            ST_CHECK:
            begin
                if (min_reg != last_reg && out_free)
                begin
                    out_valid_next = 1'b1;
                    out_min_next   = MIN_W'(min_reg);
                    out_slot_next  = count_reg;
                    out_done_next  = 1'b0;
                    last_next      = min_reg;
                    count_next     = count_reg + SLOT_W'(1);
                end
            end
            default:
            begin
                cmd_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            ptr_reg       <= '0;
            seen_reg      <= '0;
            scan_reg      <= '0;
            last_reg      <= '1;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            ptr_reg       <= ptr_next;
            seen_reg      <= seen_next;
            scan_reg      <= scan_next;
            last_reg      <= last_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hash_reg     <= hash_next;
        min_reg      <= min_next;
        out_min_reg  <= out_min_next;
        out_slot_reg <= out_slot_next;
        out_done_reg <= out_done_next;
    end

    // window memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            window_mem[ptr_reg] <= hash_reg;
        end
        rd_data_reg <= window_mem[rd_addr];
    end

endmodule

`default_nettype wire

// ----- sv/dna_minimizer_stream.sv -----
// Top level of the canonical k-mer window minimizer stream.
//
//  Channel   Dir  Signals                          Payload
//  s_axis    in   tvalid tready tdata[7:0] tlast   base; tlast = seq_end
//  m_axis    out  tvalid tready tdata[47:0] tlast  minimizer, slot; tlast = done_res
//
// Rates: the front end takes one base per cycle while the command queue has room.
// In the back end an end mark is handled in the idle state; a k-mer passes through
// fetch, seven steps of the shared hash unit and the window write, and once the
// window is full, a scan over the single read port of the window memory and a check.
// Reset: rst_n clears all control state asynchronously; the window memory holds
// no reset and is rewritten before any entry is read.
// Stalls: a result held in the output register stalls only the back end when it
// needs to emit; the front end keeps taking bases until the queue fills.
`default_nettype none

module dna_minimizer_stream
    import dmz_pkg::*;
#(
    parameter int unsigned WINDOW_LEN = 16,
    parameter int unsigned MAX_BASES  = 512
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] base
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata,   // [37:0] minimizer, [47:38] slot
    output logic             m_axis_tlast
);

    logic              q_push;
    logic              q_pop;
    logic              q_full;
    logic              q_nonempty;
    cmd_t              q_in;
    cmd_t              q_head;
    logic [MIN_W-1:0]  res_min;
    logic [SLOT_W-1:0] res_slot;

    // front end: classify each transfer, shift the k-mers, queue commands
    dmz_front #(
        .MAX_BASES (MAX_BASES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_base  (s_axis_tdata),
        .in_end   (s_axis_tlast),
        .q_full   (q_full),
        .in_ready (s_axis_tready),
        .q_push   (q_push),
        .q_cmd    (q_in)
    );

    // decouple the front end (one base per cycle while the queue has room) from the multi-cycle back end
    dmz_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_in),
        .pop      (q_pop),
        .full     (q_full),
        .nonempty (q_nonempty),
        .head     (q_head)
    );

    // back end: hash, window minimum, change detect, result register
    dmz_back #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_nonempty),
        .cmd       (q_head),
        .cmd_pop   (q_pop),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res_min   (res_min),
        .res_slot  (res_slot),
        .res_done  (m_axis_tlast)
    );

    // pack the result: minimizer in the low bits, slot above it
    assign m_axis_tdata = {res_slot, res_min};

endmodule

`default_nettype wire
